/* design/rms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_pkg: shared types for the running mean and standard error block
// Sequencer states and field widths used by the interfaces and the top level.
// ----------------------------------------------------------------------------
package rms_pkg;

   localparam int SAMPLE_BITS = 32;
   localparam int OUT_COUNT_BITS = 20;
   localparam int SUM_BITS = 64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV_MEAN,
      ST_MULT,
      ST_DIV_VAR,
      ST_SQRT,
      ST_DONE
   } state_type;

endpackage

/* design/rms_channels.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_req_if / rms_rsp_if: valid/ready channels of the statistics block
// One beat carries one sample in, or one set of statistics out.
// ----------------------------------------------------------------------------
interface rms_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [rms_pkg::SAMPLE_BITS-1:0] sample;
   logic                                 restart;
   modport source (output valid, output sample, output restart, input ready);
   modport sink (input valid, input sample, input restart, output ready);
endinterface

interface rms_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [rms_pkg::OUT_COUNT_BITS-1:0]      count;
   logic signed [rms_pkg::SAMPLE_BITS-1:0]  mean_value;
   logic [rms_pkg::SAMPLE_BITS-1:0]         std_error;
   logic                                    dropped;
   modport source (output valid, output count, output mean_value,
                   output std_error, output dropped, input ready);
   modport sink (input valid, input count, input mean_value,
                 input std_error, input dropped, output ready);
endinterface

/* design/running_mean_stderr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_mean_stderr: online mean and standard error of a sample stream
// Keeps count, mean and sum of squared deviations with Welford's update and
// reports count, mean and standard error of the mean after every sample.
// ----------------------------------------------------------------------------
// Usage: a sample beat on req (sample, restart) is taken when req.ready is
// high, which it is only while the block is idle. One result beat appears on
// rsp for every sample. A restart clears the statistics before the sample
// is added. At a full count the sample is ignored and dropped is set.
// Sequence: once the sample beat is taken the sequencer runs the mean
// division, the multiply, the variance division and the square root before
// the result beat is valid, and the next sample is taken only after the
// result beat has left, so one sample is handled at a time. A dropped sample
// skips the mean division and the multiply. The work is done by separate
// shift-and-subtract loops that run the mean division (one quotient bit a
// cycle over 33+FRAC_BITS bits), the variance division (one bit a cycle over
// 64 bits) and the square root (one result bit a cycle), and by a
// (33+FRAC_BITS)-bit by 16-bit multiplier that builds the deviation product
// in four passes at the default settings.
// While rsp.ready is low the result is held and no new sample is taken.
// Reset clears the statistics and the sequencer.
// ----------------------------------------------------------------------------
module running_mean_stderr #(
   parameter int COUNT_BITS = 20,
   parameter int FRAC_BITS = 16
) (
   input logic clock,
   input logic reset,
   rms_req_if.sink req,
   rms_rsp_if.source rsp
);

   localparam int MW = rms_pkg::SAMPLE_BITS + FRAC_BITS;
   localparam int DW = MW + 1;
   localparam int AW = (DW + 15) / 16 * 16;
   localparam int PW = 2 * DW;
   localparam int SH = 2 * FRAC_BITS;
   localparam int CNT_W = 2 * COUNT_BITS;
   localparam int ITW = 8;

   rms_pkg::state_type state_ff, state_in;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic signed [MW-1:0] mean_ff, mean_in;
   logic [63:0] dsum_ff, dsum_in;
   logic dropped_ff, dropped_in;
   logic [ITW-1:0] iter_ff, iter_in;

   logic signed [DW-1:0] xs_ff, xs_in;
   logic [DW-1:0] ad_ff, ad_in;
   logic [AW-1:0] ar_ff, ar_in;
   logic neg_ff, neg_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [63:0] quo_ff, quo_in;
   logic [CNT_W:0] rem_ff, rem_in;
   logic [CNT_W-1:0] div_ff, div_in;
   logic [65:0] srem_ff, srem_in;
   logic [31:0] root_ff, root_in;
   logic [63:0] sval_ff, sval_in;
   logic [31:0] stderr_ff, stderr_in;

   logic [CNT_W:0] rem_shift;
   logic [CNT_W:0] nwide;
   logic signed [DW-1:0] mean_ext;
   logic signed [DW-1:0] quo_s;
   logic signed [DW-1:0] rest;
   logic [PW:0] part;
   logic [CNT_W:0] vrem_shift;
   logic [65:0] srem_shift;
   logic [33:0] strial;
   logic [PW-SH-1:0] prod_sh;
   logic [64:0] sum_wide;
   logic [63:0] add_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rms_pkg::ST_IDLE;
         count_ff <= '0;
         mean_ff <= '0;
         dsum_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         mean_ff <= mean_in;
         dsum_ff <= dsum_in;
      end
   end

   always_ff @(posedge clock) begin
      dropped_ff <= dropped_in;
      iter_ff <= iter_in;
      xs_ff <= xs_in;
      ad_ff <= ad_in;
      ar_ff <= ar_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      sval_ff <= sval_in;
      stderr_ff <= stderr_in;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      mean_in = mean_ff;
      dsum_in = dsum_ff;
      dropped_in = dropped_ff;
      iter_in = iter_ff;
      xs_in = xs_ff;
      ad_in = ad_ff;
      ar_in = ar_ff;
      neg_in = neg_ff;
      acc_in = acc_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      sval_in = sval_ff;
      stderr_in = stderr_ff;
      req.ready = 1'b0;
      rsp.valid = 1'b0;

      nwide = (CNT_W + 1)'(count_ff) + (CNT_W + 1)'(1);
      mean_ext = DW'(mean_ff);
      rem_shift = {rem_ff[CNT_W-1:0], acc_ff[DW-1]};
      quo_s = neg_ff ? -$signed(acc_ff[DW-1:0]) : $signed(acc_ff[DW-1:0]);
      rest = xs_ff - (mean_ext + quo_s);
      part = '0;
      vrem_shift = {rem_ff[CNT_W-1:0], quo_ff[63]};
      srem_shift = {srem_ff[63:0], sval_ff[63:62]};
      strial = {root_ff, 2'b01};
      prod_sh = acc_ff[PW-1:SH];
      add_sat = (|prod_sh[PW-SH-1:64 < PW-SH ? 64 : PW-SH-1]) && (PW - SH > 64)
                ? {64{1'b1}} : prod_sh[63:0];
      sum_wide = {1'b0, dsum_ff} + {1'b0, add_sat};

      unique case (state_ff)
         rms_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               xs_in = DW'(req.sample) <<< FRAC_BITS;
               dropped_in = 1'b0;
               if (req.restart) begin
                  count_in = '0;
                  mean_in = '0;
                  dsum_in = '0;
               end else if (&count_ff) begin
                  dropped_in = 1'b1;
               end
               state_in = rms_pkg::ST_PREP;
            end
         end
         rms_pkg::ST_PREP: begin
            if (dropped_ff) begin
               state_in = rms_pkg::ST_DIV_VAR;
               iter_in = ITW'(1);
               quo_in = dsum_ff;
               rem_in = '0;
               div_in = CNT_W'(count_ff - COUNT_BITS'(1)) * CNT_W'(count_ff);
            end else begin
               acc_in = '0;
               acc_in[DW-1:0] = (xs_ff - mean_ext) < 0 ? DW'(-(xs_ff - mean_ext))
                                                        : DW'(xs_ff - mean_ext);
               ad_in = acc_in[DW-1:0];
               neg_in = (xs_ff - mean_ext) < 0;
               rem_in = '0;
               iter_in = '0;
               state_in = rms_pkg::ST_DIV_MEAN;
            end
         end
         rms_pkg::ST_DIV_MEAN: begin
            acc_in[DW-1:0] = {acc_ff[DW-2:0], 1'b0};
            if (rem_shift >= nwide) begin
               rem_in = rem_shift - nwide;
               acc_in[0] = 1'b1;
            end else begin
               rem_in = rem_shift;
            end
            iter_in = iter_ff + ITW'(1);
            if (iter_ff == ITW'(DW - 1)) begin
               iter_in = '0;
               state_in = rms_pkg::ST_MULT;
            end
         end
         rms_pkg::ST_MULT: begin
            if (iter_ff == '0) begin
               mean_in = MW'(mean_ext + quo_s);
               ar_in = rest < 0 ? AW'(-rest) : AW'(rest);
               acc_in = '0;
               iter_in = ITW'(1);
            end else begin
               part = (PW + 1)'(ad_ff) * (PW + 1)'(ar_ff[AW-1 -: 16]);
               acc_in = PW'((acc_ff << 16) + PW'(part));
               ar_in = ar_ff << 16;
               iter_in = iter_ff + ITW'(1);
               if (iter_ff == ITW'((DW + 15) / 16)) begin
                  iter_in = '0;
                  state_in = rms_pkg::ST_DIV_VAR;
               end
            end
         end
         rms_pkg::ST_DIV_VAR: begin
            iter_in = iter_ff + ITW'(1);
            if (iter_ff == '0 && !dropped_ff) begin
               dsum_in = sum_wide[64] ? {64{1'b1}} : sum_wide[63:0];
               count_in = count_ff + COUNT_BITS'(1);
               quo_in = sum_wide[64] ? {64{1'b1}} : sum_wide[63:0];
               rem_in = '0;
               div_in = CNT_W'(count_ff) * CNT_W'(count_ff + COUNT_BITS'(1));
            end else begin
               quo_in = {quo_ff[62:0], 1'b0};
               if (vrem_shift >= {1'b0, div_ff}) begin
                  rem_in = vrem_shift - {1'b0, div_ff};
                  quo_in[0] = 1'b1;
               end else begin
                  rem_in = vrem_shift;
               end
               if (iter_ff == ITW'(64)) begin
                  state_in = rms_pkg::ST_SQRT;
                  iter_in = '0;
                  srem_in = '0;
                  root_in = '0;
                  sval_in = quo_in;
               end
            end
         end
         rms_pkg::ST_SQRT: begin
            sval_in = {sval_ff[61:0], 2'b00};
            if (srem_shift >= 66'(strial)) begin
               srem_in = srem_shift - 66'(strial);
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               srem_in = srem_shift;
               root_in = {root_ff[30:0], 1'b0};
            end
            iter_in = iter_ff + ITW'(1);
            if (iter_ff == ITW'(31)) begin
               state_in = rms_pkg::ST_DONE;
               stderr_in = count_ff < COUNT_BITS'(2) ? '0 : root_in;
            end
         end
         rms_pkg::ST_DONE: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               state_in = rms_pkg::ST_IDLE;
            end
         end
         default: state_in = rms_pkg::ST_IDLE;
      endcase
   end

   assign rsp.count = rms_pkg::OUT_COUNT_BITS'(count_ff);
   assign rsp.mean_value = rms_pkg::SAMPLE_BITS'(mean_ff >>> FRAC_BITS);
   assign rsp.std_error = stderr_ff;
   assign rsp.dropped = dropped_ff;

endmodule
